// ----- hw/rtl/ims_pkg.sv -----
// Types and constants shared by the IR mark/space sequencer.
`timescale 1ns / 1ps
package ims_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_MARK  = 2'd1;
  localparam logic [1:0] PH_SPACE = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_BUSY    = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] mark_duration;
    logic [15:0] space_duration;
  } in_item_t;

  typedef struct packed {
    logic        carrier_gate;
    logic [1:0]  phase;
    logic [6:0]  symbol_index;
    logic [7:0]  symbols_loaded;
    logic        done_res;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] mark;
    logic [15:0] space;
  } sym_t;

endpackage

// ----- hw/rtl/ims_store.sv -----
// Symbol store: one write port, one registered read port.
`timescale 1ns / 1ps
module ims_store #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  ims_pkg::sym_t  wdata_i,
  input  logic [AW-1:0]  raddr_i,
  output ims_pkg::sym_t  rdata_o
);
  import ims_pkg::*;

  sym_t mem_q [DEPTH];
  sym_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/ims_outbuf.sv -----
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps
module ims_outbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ims_pkg::out_item_t  push_data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ims_pkg::out_item_t  out_data_o
);
  import ims_pkg::*;

  logic      main_valid_q, main_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t main_q, main_d;
  out_item_t skid_q, skid_d;
  logic      pop;

  assign pop = main_valid_q && !out_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

endmodule

// ----- hw/rtl/ims_core.sv -----
// Sequencer control: command decode, phase timing and store access.
`timescale 1ns / 1ps
module ims_core #(
  parameter int MAX_SYMBOLS = 128,
  parameter int AW          = 7,
  parameter int CW          = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  ims_pkg::in_item_t   item_i,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_data_i,
  output logic                we_o,
  output logic [AW-1:0]       waddr_o,
  output ims_pkg::sym_t       wdata_o,
  output logic [AW-1:0]       raddr_o,
  input  ims_pkg::sym_t       rdata_i,
  output ims_pkg::out_item_t  res_o
);
  import ims_pkg::*;

  logic [1:0]    phase_q, phase_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [15:0]   pe_q, pe_d;
  logic [31:0]   se_q, se_d;
  logic [31:0]   timeout_q;
  sym_t          sym_q, sym_d;

  logic          busy;
  logic          full;
  logic [CW-1:0] nxt_idx;
  logic [15:0]   dur;
  logic [15:0]   pe_inc;
  logic [31:0]   se_inc;
  logic          finished;
  logic          done;
  logic [2:0]    status;
  logic [31:0]   idx_ext;
  logic [31:0]   count_ext;

  assign busy    = phase_q != PH_IDLE;
  assign full    = count_q >= CW'(MAX_SYMBOLS);
  assign nxt_idx = CW'(idx_q) + CW'(1);
  assign dur     = (phase_q == PH_MARK) ? sym_q.mark : sym_q.space;
  assign pe_inc  = (pe_q != 16'hFFFF) ? pe_q + 16'd1 : pe_q;
  assign se_inc  = (se_q != 32'hFFFF_FFFF) ? se_q + 32'd1 : se_q;

  assign raddr_o = nxt_idx[AW-1:0];
  assign waddr_o = count_q[AW-1:0];
  assign wdata_o = {item_i.mark_duration, item_i.space_duration};

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    idx_d    = idx_q;
    pe_d     = pe_q;
    se_d     = se_q;
    sym_d    = sym_q;
    we_o     = 1'b0;
    finished = 1'b0;
    done     = 1'b0;
    status   = ST_OK;
    if (accept_i) begin
      case (item_i.cmd)
        CMD_LOAD: begin
          if (busy) begin
            status = ST_BUSY;
          end else if (full) begin
            status = ST_FULL;
          end else begin
            we_o    = 1'b1;
            count_d = count_q + CW'(1);
            if (count_q == '0) begin
              sym_d = wdata_o;
            end
          end
        end
        CMD_START: begin
          if (busy) begin
            status = ST_BUSY;
          end else if (count_q == '0) begin
            status = ST_EMPTY;
          end else begin
            phase_d = PH_MARK;
            idx_d   = '0;
            pe_d    = '0;
            se_d    = '0;
          end
        end
        CMD_TICK: begin
          if (busy) begin
            pe_d = pe_inc;
            se_d = se_inc;
            if (pe_inc >= dur) begin
              pe_d = '0;
              if (phase_q == PH_MARK) begin
                phase_d = PH_SPACE;
              end else if (nxt_idx >= count_q) begin
                finished = 1'b1;
                done     = 1'b1;
              end else begin
                phase_d = PH_MARK;
                idx_d   = nxt_idx[AW-1:0];
                sym_d   = rdata_i;
              end
            end
            if (!finished && se_inc >= timeout_q) begin
              status = ST_TIMEOUT;
            end
            if (finished || status == ST_TIMEOUT) begin
              phase_d = PH_IDLE;
              idx_d   = '0;
              pe_d    = '0;
              se_d    = '0;
              count_d = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      pe_q    <= '0;
      se_q    <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      pe_q    <= pe_d;
      se_q    <= se_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
  end

  assign idx_ext   = 32'(idx_d);
  assign count_ext = 32'(count_d);

  always_comb begin
    res_o.carrier_gate   = phase_d == PH_MARK;
    res_o.phase          = phase_d;
    res_o.symbol_index   = idx_ext[6:0];
    res_o.symbols_loaded = count_ext[7:0];
    res_o.done_res       = done;
    res_o.status         = status;
  end

endmodule

// ----- hw/rtl/ir_mark_space_sequencer_top.sv -----
// Top level of the IR mark/space transmit sequencer.
// One beat in, one result beat out, at one beat per cycle unless stalled.
// Each beat is decoded and its state updated combinationally; the result
// sits in a two-entry output register pair, so input keeps flowing while one
// result waits. Symbols live in a MAX_SYMBOLS-deep memory with a registered
// read; the symbol after the current one is prefetched every cycle, and a
// mark always lies between two index steps, so no beat ever waits on the read
// port. The store is not cleared after reset and needs no clearing pass.
`timescale 1ns / 1ps
module ir_mark_space_sequencer_top #(
  parameter int MAX_SYMBOLS = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ims_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ims_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);
  import ims_pkg::*;

  localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CW = $clog2(MAX_SYMBOLS + 1);

  logic          accept;
  logic          buf_full;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  sym_t          wdata;
  sym_t          rdata;
  out_item_t     res;

  assign accept      = in_valid_i && !buf_full;
  assign in_stall_o  = buf_full;
  assign cfg_ready_o = 1'b1;

  ims_core #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .AW          (AW),
    .CW          (CW)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr),
    .rdata_i    (rdata),
    .res_o      (res)
  );

  ims_store #(
    .DEPTH (MAX_SYMBOLS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ims_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hw/rtl/ims_checker.sv -----
// Port-level checks for the IR mark/space sequencer and their bind.
`timescale 1ns / 1ps
module ims_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ims_pkg::out_item_t  out_data_o
);
  import ims_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_gate_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.carrier_gate == (out_data_o.phase == PH_MARK))
    else $error("carrier gate disagrees with phase");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |->
      out_data_o.phase == PH_IDLE && out_data_o.symbols_loaded == 8'd0 &&
      out_data_o.symbol_index == 7'd0 && out_data_o.status == ST_OK)
    else $error("done without clean return to idle");

  a_timeout_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_TIMEOUT |->
      out_data_o.phase == PH_IDLE && out_data_o.symbols_loaded == 8'd0 &&
      !out_data_o.done_res)
    else $error("timeout without emptying the store");

endmodule

bind ir_mark_space_sequencer_top ims_checker u_ims_checker (.*);
